// ----- rtl/core/jsm_pkg.sv -----
// jsm_pkg: shared types and constants for the JTAG scan master.
// Used by jsm_ctrl, jsm_dp and jtag_scan_master; depends on nothing.
package jsm_pkg;

  // Default sizes for the top-level parameters
  localparam int MAX_SCAN_BITS_DEF = 32;
  localparam int MAX_PULSES_DEF    = 31;

  // Command codes
  localparam logic [2:0] OP_IR_SCAN  = 3'd0;
  localparam logic [2:0] OP_DR_SCAN  = 3'd1;
  localparam logic [2:0] OP_TCLK_LO  = 3'd2;
  localparam logic [2:0] OP_TCLK_HI  = 3'd3;
  localparam logic [2:0] OP_PULSE_P  = 3'd4;
  localparam logic [2:0] OP_PULSE_N  = 3'd5;

  // 20-bit DR (address) scans get their capture rotated into address order
  localparam int          ADDR_SCAN_BITS = 20;
  localparam logic [31:0] ADDR20_MASK    = 32'h000F_FFFF;

  // Input beat
  typedef struct packed {
    logic [2:0]  operation;
    logic [5:0]  bit_count;
    logic [31:0] shift_data;
    logic [31:0] tdo_levels;
    logic [4:0]  pulse_count;
  } in_t;

  // Result beat
  typedef struct packed {
    logic        tms_level;
    logic        tdi_level;
    logic        tclk_level;
    logic        is_tck_cycle;
    logic [31:0] captured;
    logic        last;
  } out_t;

  // Kind of result item the datapath builds on an emit
  typedef enum logic [2:0] {
    K_ENTRY = 3'd0,
    K_SHIFT = 3'd1,
    K_EXIT1 = 3'd2,
    K_EXIT2 = 3'd3,
    K_TCLK  = 3'd4,
    K_PH1   = 3'd5,
    K_PH2   = 3'd6
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic  load;
    logic  emit;
    kind_t kind;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic new_scan;
    logic new_tclk;
    logic new_pulse;
    logic entry_done;
    logic shift_done;
    logic pulse_done;
    logic can_emit;
  } sts_t;

endpackage

// ----- rtl/core/jsm_ctrl.sv -----
// jsm_ctrl: command sequencer for the JTAG scan master.
// Depends on jsm_pkg; drives jsm_dp through cmd_t and reads sts_t.
module jsm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  jsm_pkg::sts_t sts,
  output jsm_pkg::cmd_t cmd
);
  import jsm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ENTRY = 8'b0000_0010,
    S_SHIFT = 8'b0000_0100,
    S_EXIT1 = 8'b0000_1000,
    S_EXIT2 = 8'b0001_0000,
    S_TCLK  = 8'b0010_0000,
    S_PH1   = 8'b0100_0000,
    S_PH2   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   idle;
  kind_t  kind;

  assign idle     = (state_r == S_IDLE);
  assign in_stall = !idle;

  // Command outputs
  assign cmd.load = idle && in_valid;
  assign cmd.emit = !idle && sts.can_emit;
  assign cmd.kind = kind;

  always_comb begin
    unique case (state_r)
      S_ENTRY: kind = K_ENTRY;
      S_SHIFT: kind = K_SHIFT;
      S_EXIT1: kind = K_EXIT1;
      S_EXIT2: kind = K_EXIT2;
      S_PH1:   kind = K_PH1;
      S_PH2:   kind = K_PH2;
      default: kind = K_TCLK;
    endcase
  end

  // Next state; every non-idle state moves only when its item goes out
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          priority if (sts.new_scan)  state_nxt = S_ENTRY;
          else if (sts.new_tclk)      state_nxt = S_TCLK;
          else if (sts.new_pulse)     state_nxt = S_PH1;
          else                        state_nxt = S_IDLE;
        end
      end
      S_ENTRY: if (cmd.emit && sts.entry_done) state_nxt = S_SHIFT;
      S_SHIFT: if (cmd.emit && sts.shift_done) state_nxt = S_EXIT1;
      S_EXIT1: if (cmd.emit) state_nxt = S_EXIT2;
      S_EXIT2: if (cmd.emit) state_nxt = S_IDLE;
      S_TCLK:  if (cmd.emit) state_nxt = S_IDLE;
      S_PH1:   if (cmd.emit) state_nxt = S_PH2;
      S_PH2: begin
        if (cmd.emit) state_nxt = sts.pulse_done ? S_IDLE : S_PH1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/jsm_dp.sv -----
// jsm_dp: datapath of the JTAG scan master: command registers, bit and
// pulse counters, line state and the result register. Depends on jsm_pkg.
module jsm_dp #(
  parameter int MAX_SCAN_BITS = jsm_pkg::MAX_SCAN_BITS_DEF,
  parameter int MAX_PULSES    = jsm_pkg::MAX_PULSES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  jsm_pkg::in_t  in_data,
  input  jsm_pkg::cmd_t cmd,
  output jsm_pkg::sts_t sts,
  input  logic          out_stall,
  output logic          out_valid,
  output jsm_pkg::out_t out_data
);
  import jsm_pkg::*;

  localparam int CW      = $clog2(MAX_SCAN_BITS);
  localparam int PW      = $clog2(MAX_PULSES + 1);
  localparam int CLAMP_W = 9;

  logic [MAX_SCAN_BITS-1:0] sdata_r;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [1:0]               ent_r, ent_nxt;
  logic [PW-1:0]            pcnt_r, pcnt_nxt;
  logic [31:0]              cap_r;
  logic                     first_r;
  logic                     tclk_set_r;
  logic                     tclk_state_r, tclk_state_nxt;
  logic                     tdi_state_r, tdi_state_nxt;
  logic                     out_valid_r;
  out_t                     out_r;

  // Load-time decode and clamping
  logic [CLAMP_W-1:0]              bc_w, nc_w, pc_w, pcl_w;
  logic [MAX_SCAN_BITS+31:0]       sdata_ext;
  logic [31:0]                     mask, cap_m, cap_rot, cap_ld;
  logic                            op_scan, op_tclk, op_pulse;
  out_t                            item;
  logic                            shift_bit;

  assign op_scan  = (in_data.operation == OP_IR_SCAN) || (in_data.operation == OP_DR_SCAN);
  assign op_tclk  = (in_data.operation == OP_TCLK_LO) || (in_data.operation == OP_TCLK_HI);
  assign op_pulse = (in_data.operation == OP_PULSE_P) || (in_data.operation == OP_PULSE_N);

  assign bc_w = CLAMP_W'(in_data.bit_count);
  assign pc_w = CLAMP_W'(in_data.pulse_count);

  always_comb begin
    priority if (bc_w == '0)                        nc_w = CLAMP_W'(1);
    else if (bc_w > CLAMP_W'(MAX_SCAN_BITS))        nc_w = CLAMP_W'(MAX_SCAN_BITS);
    else                                            nc_w = bc_w;
    priority if (pc_w == '0)                        pcl_w = CLAMP_W'(1);
    else if (pc_w > CLAMP_W'(MAX_PULSES))           pcl_w = CLAMP_W'(MAX_PULSES);
    else                                            pcl_w = pc_w;
  end

  // Data bits above bit 31 read as zero
  assign sdata_ext = {{MAX_SCAN_BITS{1'b0}}, in_data.shift_data};

  // Capture mask and address-order rotation
  always_comb begin
    for (int i = 0; i < 32; i++) begin
      mask[i] = (CLAMP_W'(i) < nc_w);
    end
  end
  assign cap_m   = in_data.tdo_levels & mask;
  assign cap_rot = ((cap_m << 16) + (cap_m >> 4)) & ADDR20_MASK;
  assign cap_ld  = ((in_data.operation == OP_DR_SCAN) && (nc_w == CLAMP_W'(ADDR_SCAN_BITS)))
                   ? cap_rot : cap_m;

  // Status to the controller
  assign sts.new_scan   = op_scan;
  assign sts.new_tclk   = op_tclk;
  assign sts.new_pulse  = op_pulse;
  assign sts.entry_done = (ent_r == 2'd3);
  assign sts.shift_done = (cnt_r == '0);
  assign sts.pulse_done = (pcnt_r == PW'(1));
  assign sts.can_emit   = !out_valid_r || !out_stall;

  assign shift_bit = sdata_r[cnt_r];

  // Build the result item for the current kind
  always_comb begin
    item.tms_level    = 1'b0;
    item.tdi_level    = tdi_state_r;
    item.tclk_level   = tclk_state_r;
    item.is_tck_cycle = 1'b1;
    item.captured     = '0;
    item.last         = 1'b0;
    unique case (cmd.kind)
      K_ENTRY: item.tms_level = ~ent_r[1];
      K_SHIFT: begin
        item.tms_level = (cnt_r == '0);
        item.tdi_level = shift_bit;
      end
      K_EXIT1: item.tms_level = 1'b1;
      K_EXIT2: begin
        item.captured = cap_r;
        item.last     = 1'b1;
      end
      K_TCLK: begin
        item.tclk_level   = tclk_set_r;
        item.is_tck_cycle = 1'b0;
        item.last         = 1'b1;
      end
      K_PH1: begin
        item.tclk_level   = first_r;
        item.is_tck_cycle = 1'b0;
      end
      K_PH2: begin
        item.tclk_level   = ~first_r;
        item.is_tck_cycle = 1'b0;
        item.last         = (pcnt_r == PW'(1));
      end
      default: item.is_tck_cycle = 1'b0;
    endcase
  end

  // Counter and line-state updates on each emitted beat
  always_comb begin
    cnt_nxt        = cnt_r;
    ent_nxt        = ent_r;
    pcnt_nxt       = pcnt_r;
    tclk_state_nxt = tclk_state_r;
    tdi_state_nxt  = tdi_state_r;
    if (cmd.emit) begin
      unique case (cmd.kind)
        K_ENTRY: ent_nxt = ent_r + 2'd1;
        K_SHIFT: begin
          cnt_nxt       = cnt_r - CW'(1);
          tdi_state_nxt = shift_bit;
        end
        K_TCLK, K_PH1: tclk_state_nxt = item.tclk_level;
        K_PH2: begin
          tclk_state_nxt = item.tclk_level;
          pcnt_nxt       = pcnt_r - PW'(1);
        end
        default: ;
      endcase
    end
  end

  // Command registers, loaded on accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sdata_r    <= sdata_ext[MAX_SCAN_BITS-1:0];
      cnt_r      <= CW'(nc_w - CLAMP_W'(1));
      ent_r      <= (in_data.operation == OP_IR_SCAN) ? 2'd0 : 2'd1;
      pcnt_r     <= PW'(pcl_w);
      cap_r      <= cap_ld;
      first_r    <= (in_data.operation == OP_PULSE_P);
      tclk_set_r <= (in_data.operation == OP_TCLK_HI);
    end else begin
      cnt_r  <= cnt_nxt;
      ent_r  <= ent_nxt;
      pcnt_r <= pcnt_nxt;
    end
  end

  // Line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tclk_state_r <= 1'b0;
      tdi_state_r  <= 1'b0;
    end else begin
      tclk_state_r <= tclk_state_nxt;
      tdi_state_r  <= tdi_state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/jtag_scan_master.sv -----
// jtag_scan_master: one command at a time; the first result beat is built in the first state
// after the accept and registered, then one result beat per clock unless stalled.
// Scans step through entry, shift and exit beats, TCLK set/clear and pulses through TCLK beats,
// all paced by the single result register (one beat per cycle unless stalled).
// A new command is taken once the sequencer is idle again; reserved codes produce no beats.
// Reset (rst_n low, synchronous): sequencer idle, TCLK and TDI state low.
module jtag_scan_master #(
  parameter int MAX_SCAN_BITS = jsm_pkg::MAX_SCAN_BITS_DEF,
  parameter int MAX_PULSES    = jsm_pkg::MAX_PULSES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  jsm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output jsm_pkg::out_t out_data
);
  import jsm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  jsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  jsm_dp #(
    .MAX_SCAN_BITS (MAX_SCAN_BITS),
    .MAX_PULSES    (MAX_PULSES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A new result never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

  // An accepted scan keeps the input side stalled next cycle
  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && sts.new_scan) |=> in_stall)
    else $error("input taken during a scan");

  // Captured data only on the final beat
  a_cap_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> (out_data.captured == '0))
    else $error("captured word on a non-final beat");

  // No beat is built in the cycle a command is accepted
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cmd.emit)
    else $error("emit during command load");

endmodule

// ----- tb/jsm_checker.sv -----
// jsm_checker: watches both channels of jtag_scan_master, predicts the TMS/TDI/TCLK
// beats of every accepted command and compares each result beat in order.
// Depends on jsm_pkg for the command codes and the beat structs.
`timescale 1ns / 100ps

module jsm_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  jsm_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  jsm_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);
  import jsm_pkg::*;

  out_t exp_beats[$];
  logic tclk_lvl;
  logic tdi_lvl;
  int   mismatches = 0;

  assign fail_count = mismatches;

  // queue one expected result beat
  function automatic void push_beat(logic tms, logic tdi, logic tclk, logic tck,
                                    logic [31:0] cap, logic fin);
    out_t b;
    b.tms_level    = tms;
    b.tdi_level    = tdi;
    b.tclk_level   = tclk;
    b.is_tck_cycle = tck;
    b.captured     = cap;
    b.last         = fin;
    exp_beats.push_back(b);
  endfunction

  // expand one command into its expected result beats
  function automatic void predict_command(in_t c);
    int unsigned nbits;
    int unsigned npulse;
    int unsigned entry_len;
    logic [3:0]  entry_tms;
    logic [31:0] mask;
    logic [31:0] cap;
    logic        tdi;
    logic        first;
    unique case (c.operation)
      OP_IR_SCAN, OP_DR_SCAN: begin
        nbits = 32'(c.bit_count);
        if (nbits < 1) nbits = 1;
        if (nbits > MAX_SCAN_BITS_DEF) nbits = MAX_SCAN_BITS_DEF;
        tdi = tdi_lvl;
        // walk from Run-Test/Idle to Shift-IR (1,1,0,0) or Shift-DR (1,0,0)
        entry_tms = (c.operation == OP_IR_SCAN) ? 4'b1100 : 4'b1000;
        entry_len = (c.operation == OP_IR_SCAN) ? 4 : 3;
        for (int unsigned k = 0; k < entry_len; k++)
          push_beat(entry_tms[3 - k], tdi, tclk_lvl, 1'b1, 32'h0, 1'b0);
        // shift MSB first, TMS high on the last bit
        for (int unsigned k = 0; k < nbits; k++) begin
          tdi = c.shift_data[nbits - 1 - k];
          push_beat(k == nbits - 1, tdi, tclk_lvl, 1'b1, 32'h0, 1'b0);
        end
        mask = (nbits >= 32) ? 32'hFFFF_FFFF : ((32'h1 << nbits) - 32'h1);
        cap  = c.tdo_levels & mask;
        // 20-bit address capture is rotated into address order
        if (c.operation == OP_DR_SCAN && nbits == ADDR_SCAN_BITS)
          cap = ((cap << 16) + (cap >> 4)) & ADDR20_MASK;
        push_beat(1'b1, tdi, tclk_lvl, 1'b1, 32'h0, 1'b0);
        push_beat(1'b0, tdi, tclk_lvl, 1'b1, cap, 1'b1);
        tdi_lvl = tdi;
      end
      OP_TCLK_LO, OP_TCLK_HI: begin
        tclk_lvl = (c.operation == OP_TCLK_HI);
        push_beat(1'b0, tdi_lvl, tclk_lvl, 1'b0, 32'h0, 1'b1);
      end
      OP_PULSE_P, OP_PULSE_N: begin
        first  = (c.operation == OP_PULSE_P);
        npulse = 32'(c.pulse_count);
        if (npulse < 1) npulse = 1;
        if (npulse > MAX_PULSES_DEF) npulse = MAX_PULSES_DEF;
        for (int unsigned k = 0; k < npulse; k++) begin
          push_beat(1'b0, tdi_lvl, first, 1'b0, 32'h0, 1'b0);
          push_beat(1'b0, tdi_lvl, !first, 1'b0, 32'h0, k == npulse - 1);
        end
        tclk_lvl = !first;
      end
      default: ; // reserved codes: no beats, state untouched
    endcase
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      exp_beats.delete();
      tclk_lvl = 1'b0;
      tdi_lvl  = 1'b0;
    end else begin
      // compare accepted result beat against the oldest expectation
      if (out_valid && !out_stall) begin
        if (exp_beats.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %p", $time, out_data);
          mismatches++;
        end else begin
          want = exp_beats.pop_front();
          check_field("tms_level",    32'(want.tms_level),    32'(out_data.tms_level));
          check_field("tdi_level",    32'(want.tdi_level),    32'(out_data.tdi_level));
          check_field("tclk_level",   32'(want.tclk_level),   32'(out_data.tclk_level));
          check_field("is_tck_cycle", 32'(want.is_tck_cycle), 32'(out_data.is_tck_cycle));
          check_field("captured",     want.captured,          out_data.captured);
          check_field("last",         32'(want.last),         32'(out_data.last));
        end
      end
      // accepted command beat
      if (in_valid && !in_stall)
        predict_command(in_data);
    end
    pending <= exp_beats.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// tb_top: clock, reset and command stimulus for jtag_scan_master, random result
// back-pressure and the final verdict. Depends on jsm_pkg and jsm_checker.
`timescale 1ns / 100ps

module tb_top;
  import jsm_pkg::*;

  // reserved command codes the block must ignore
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;
  localparam int         NUM_CMDS  = 330;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  int   fail_count;
  int   pending;

  logic send_burst = 1'b0;

  jtag_scan_master dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  jsm_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic in_t make_cmd(logic [2:0] op, logic [5:0] nbits, logic [31:0] sdata,
                                   logic [31:0] tdo, logic [4:0] npulse);
    in_t c;
    c.operation   = op;
    c.bit_count   = nbits;
    c.shift_data  = sdata;
    c.tdo_levels  = tdo;
    c.pulse_count = npulse;
    return c;
  endfunction

  // mostly well-formed commands; a few reserved codes and out-of-range counts
  function automatic in_t rand_cmd();
    in_t         c;
    int unsigned r;
    c.shift_data = $urandom();
    c.tdo_levels = $urandom();
    r = $urandom_range(0, 99);
    if (r < 30)      c.operation = OP_IR_SCAN;
    else if (r < 60) c.operation = OP_DR_SCAN;
    else if (r < 68) c.operation = OP_TCLK_LO;
    else if (r < 76) c.operation = OP_TCLK_HI;
    else if (r < 86) c.operation = OP_PULSE_P;
    else if (r < 96) c.operation = OP_PULSE_N;
    else             c.operation = $urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7;
    r = $urandom_range(0, 9);
    if (r < 2)       c.bit_count = 6'($urandom_range(0, 63));
    else if (r < 4)  c.bit_count = (c.operation == OP_IR_SCAN) ? 6'd8 : 6'(ADDR_SCAN_BITS);
    else             c.bit_count = 6'($urandom_range(1, MAX_SCAN_BITS_DEF));
    c.pulse_count = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(1, 6));
    return c;
  endfunction

  // idle cycles before the next command; burst stretches have none
  function automatic int next_gap();
    if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
    return send_burst ? 0 : $urandom_range(0, 13);
  endfunction

  // offer one command and hold it until the block takes it
  task automatic send_cmd(in_t c);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // result side: random stall per beat, quiet stretches, and a long hold-off
  initial begin : result_sink
    int unsigned wait_left;
    int unsigned beats;
    logic        quiet;
    wait_left = 0;
    beats     = 0;
    quiet     = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        beats++;
        if ($urandom_range(0, 59) == 0) quiet = !quiet;
        if (beats % 1500 == 0) wait_left = 400;
        else                   wait_left = quiet ? 0 : $urandom_range(0, 13);
        out_stall <= (wait_left != 0);
      end else if (wait_left != 0) begin
        wait_left--;
        out_stall <= (wait_left != 0);
      end
    end
  end

  // command stimulus
  initial begin : cmd_source
    in_t c;
    int  sent;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, every command, clamping and reserved codes
    send_cmd(make_cmd(OP_IR_SCAN, 6'd8,  32'h0000_00A5, 32'h0000_005A, 5'd1));
    send_cmd(make_cmd(OP_DR_SCAN, 6'd20, 32'h000F_FFFF, 32'h0001_2345, 5'd1));
    send_cmd(make_cmd(OP_DR_SCAN, 6'd20, 32'h0000_0000, 32'hFFFF_FFFF, 5'd1));
    send_cmd(make_cmd(OP_DR_SCAN, 6'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1));
    send_cmd(make_cmd(OP_IR_SCAN, 6'd32, 32'h0000_0000, 32'h0000_0000, 5'd1));
    send_cmd(make_cmd(OP_DR_SCAN, 6'd1,  32'h0000_0001, 32'hFFFF_FFFF, 5'd1));
    send_cmd(make_cmd(OP_IR_SCAN, 6'd0,  32'hFFFF_FFFE, 32'h0000_0001, 5'd1));
    send_cmd(make_cmd(OP_DR_SCAN, 6'd63, $urandom(), $urandom(), 5'd1));
    send_cmd(make_cmd(OP_DR_SCAN, 6'd33, $urandom(), $urandom(), 5'd1));
    send_cmd(make_cmd(OP_DR_SCAN, 6'd19, $urandom(), $urandom(), 5'd1));
    send_cmd(make_cmd(OP_DR_SCAN, 6'd21, $urandom(), $urandom(), 5'd1));
    send_cmd(make_cmd(OP_IR_SCAN, 6'd20, $urandom(), 32'hFFFF_FFFF, 5'd1));
    send_cmd(make_cmd(OP_TCLK_HI, 6'd8,  32'h0, 32'h0, 5'd0));
    send_cmd(make_cmd(OP_DR_SCAN, 6'd8,  32'h0000_0055, 32'h0000_00AA, 5'd0));
    send_cmd(make_cmd(OP_TCLK_LO, 6'd8,  32'h0, 32'h0, 5'd0));
    send_cmd(make_cmd(OP_TCLK_HI, 6'd8,  32'h0, 32'h0, 5'd0));
    send_cmd(make_cmd(OP_PULSE_P, 6'd8,  32'h0, 32'h0, 5'd1));
    send_cmd(make_cmd(OP_PULSE_P, 6'd8,  32'h0, 32'h0, 5'd31));
    send_cmd(make_cmd(OP_PULSE_N, 6'd8,  32'h0, 32'h0, 5'd0));
    send_cmd(make_cmd(OP_PULSE_N, 6'd8,  32'h0, 32'h0, 5'd31));
    send_cmd(make_cmd(OP_RSVD_6,  6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31));
    send_cmd(make_cmd(OP_RSVD_7,  6'd8,  32'h0, 32'h0, 5'd3));
    send_cmd(make_cmd(OP_TCLK_LO, 6'd0,  32'h0, 32'h0, 5'd0));
    wait_results_drained();

    // random commands; reserved codes do not count
    sent = 0;
    while (sent < NUM_CMDS) begin
      c = rand_cmd();
      send_cmd(c);
      if (c.operation != OP_RSVD_6 && c.operation != OP_RSVD_7) sent++;
      if (sent == NUM_CMDS / 2) wait_results_drained();
    end

    wait_results_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
